// ===== rtl/core/source_char_tokenizer_core_defines.svh =====
// Assertion helpers shared by the tokenizer modules.
`ifndef SOURCE_CHAR_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_CHAR_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STK_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stk: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define STK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stk: next-cycle check failed");

`endif

// ===== rtl/core/stk_pkg.sv =====
package stk_pkg;

   // token kinds and error codes as they leave the block
   typedef enum logic [2:0] {
      KIND_IDENT  = 3'd0,
      KIND_INT    = 3'd1,
      KIND_FLOAT  = 3'd2,
      KIND_SYMBOL = 3'd3,
      KIND_EOF    = 3'd4,
      KIND_ERROR  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_UNEXPECTED  = 2'd1,
      ERR_NO_FRACTION = 2'd2
   } err_type;

   // request command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // character constants
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // operator table size and result queue geometry
   localparam int OP_COUNT    = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [5:0] sym_type;
   typedef logic [3:0] op_idx_type;

   typedef struct packed {
      sym_type    base;
      logic [1:0] n_ext;
      logic [7:0] ext1;
      logic [7:0] ext2;
   } op_info_type;

   typedef struct packed {
      logic    hit;
      sym_type sym;
   } single_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c == CH_USCORE) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
   endfunction

   // one-character punctuation that never extends
   function automatic single_type single_code(input logic [7:0] c);
      single_type r;
      r.hit = 1'b1;
      unique case (c)
         8'h28:   r.sym = 6'd0;
         8'h29:   r.sym = 6'd1;
         8'h5B:   r.sym = 6'd2;
         8'h5D:   r.sym = 6'd3;
         8'h7B:   r.sym = 6'd4;
         8'h7D:   r.sym = 6'd5;
         CH_DOT:  r.sym = 6'd6;
         8'h2C:   r.sym = 6'd7;
         8'h3A:   r.sym = 6'd8;
         8'h3B:   r.sym = 6'd9;
         default: begin
            r.hit = 1'b0;
            r.sym = 6'd0;
         end
      endcase
      return r;
   endfunction

   // operator lead characters, numbered from one; zero means none
   function automatic op_idx_type op_code(input logic [7:0] c);
      op_idx_type r;
      unique case (c)
         8'h2A:    r = 4'd1;
         8'h2F:    r = 4'd2;
         8'h25:    r = 4'd3;
         8'h2B:    r = 4'd4;
         8'h2D:    r = 4'd5;
         8'h3C:    r = 4'd6;
         8'h3E:    r = 4'd7;
         CH_EQUAL: r = 4'd8;
         8'h21:    r = 4'd9;
         8'h26:    r = 4'd10;
         8'h7C:    r = 4'd11;
         8'h5E:    r = 4'd12;
         default:  r = 4'd0;
      endcase
      return r;
   endfunction

   // base symbol and allowed second characters of each operator
   function automatic op_info_type op_info(input op_idx_type idx);
      op_info_type r;
      unique case (idx)
         4'd1:    r = '{6'd10, 2'd1, CH_EQUAL, 8'h00};
         4'd2:    r = '{6'd12, 2'd2, 8'h2F, 8'h2A};
         4'd3:    r = '{6'd15, 2'd1, CH_EQUAL, 8'h00};
         4'd4:    r = '{6'd17, 2'd2, 8'h2B, CH_EQUAL};
         4'd5:    r = '{6'd20, 2'd2, 8'h2D, CH_EQUAL};
         4'd6:    r = '{6'd23, 2'd2, 8'h3C, CH_EQUAL};
         4'd7:    r = '{6'd26, 2'd2, 8'h3E, CH_EQUAL};
         4'd8:    r = '{6'd29, 2'd1, CH_EQUAL, 8'h00};
         4'd9:    r = '{6'd31, 2'd1, CH_EQUAL, 8'h00};
         4'd10:   r = '{6'd33, 2'd1, 8'h26, 8'h00};
         4'd11:   r = '{6'd35, 2'd1, 8'h7C, 8'h00};
         4'd12:   r = '{6'd37, 2'd1, 8'h5E, 8'h00};
         default: r = '{6'd0, 2'd0, 8'h00, 8'h00};
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/stk_if.sv =====
// request channel: one source byte or end of data per beat
interface stk_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] char_byte;

   modport source (output valid, cmd, char_byte, input ready);
   modport sink   (input valid, cmd, char_byte, output ready);
endinterface

// response channel: one token per beat
interface stk_rsp_if #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [2:0]             token_kind;
   logic [5:0]             symbol_code;
   logic [1:0]             error_code;
   logic [LINE_BITS-1:0]   token_line;
   logic [COLUMN_BITS-1:0] start_column;
   logic [LENGTH_BITS-1:0] token_length;
   logic                   last_of_run;

   modport source (output valid, token_kind, symbol_code, error_code, token_line,
                   start_column, token_length, last_of_run, input ready);
   modport sink   (input valid, token_kind, symbol_code, error_code, token_line,
                   start_column, token_length, last_of_run, output ready);
endinterface

// ===== rtl/core/stk_scan.sv =====
`include "source_char_tokenizer_core_defines.svh"

module stk_scan #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16,
   parameter int RES_W       = 12 + LINE_BITS + COLUMN_BITS + LENGTH_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic             cmd,
   input  logic [7:0]       char_byte,
   output logic [1:0]       res_n,
   output logic [RES_W-1:0] res_a,
   output logic [RES_W-1:0] res_b
);

   typedef enum logic [2:0] {
      M_IDLE  = 3'd0,
      M_IDENT = 3'd1,
      M_INT   = 3'd2,
      M_DOT   = 3'd3,
      M_FRAC  = 3'd4,
      M_OPER  = 3'd5,
      M_ERROR = 3'd6
   } mode_type;

   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
   localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LEN_TWO  = LENGTH_BITS'(2);

   mode_type                mode_ff, mode_in;
   stk_pkg::op_idx_type     pend_ff, pend_in;
   logic [LINE_BITS-1:0]    line_ff, line_in;
   logic [COLUMN_BITS-1:0]  col_ff, col_in;
   logic [LINE_BITS-1:0]    tsl_ff, tsl_in;
   logic [COLUMN_BITS-1:0]  tsc_ff, tsc_in;
   logic [LENGTH_BITS-1:0]  cnt_ff, cnt_in;

   logic [LENGTH_BITS-1:0]  cnt_inc;
   stk_pkg::op_info_type    oi;
   stk_pkg::single_type     sc;
   stk_pkg::op_idx_type     oc;
   logic                    restart;

   // the token that ends here, and the one that the restart byte emits
   logic                    e0_vld, e1_vld;
   stk_pkg::kind_type       e0_kind, e1_kind;
   stk_pkg::sym_type        e0_sym, e1_sym;
   stk_pkg::err_type        e0_err, e1_err;
   logic [LINE_BITS-1:0]    e0_line, e1_line;
   logic [COLUMN_BITS-1:0]  e0_col, e1_col;
   logic [LENGTH_BITS-1:0]  e0_len, e1_len;

   assign cnt_inc = (cnt_ff == '1) ? cnt_ff : cnt_ff + LEN_ONE;
   assign oi      = stk_pkg::op_info(pend_ff);
   assign sc      = stk_pkg::single_code(char_byte);
   assign oc      = stk_pkg::op_code(char_byte);

   // decide tokens and next scan state for the item at hand
   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      line_in = line_ff;
      col_in  = col_ff;
      tsl_in  = tsl_ff;
      tsc_in  = tsc_ff;
      cnt_in  = cnt_ff;
      restart = 1'b0;
      e0_vld  = 1'b0;
      e0_kind = stk_pkg::KIND_IDENT;
      e0_sym  = '0;
      e0_err  = stk_pkg::ERR_NONE;
      e0_line = tsl_ff;
      e0_col  = tsc_ff;
      e0_len  = cnt_ff;
      e1_vld  = 1'b0;
      e1_kind = stk_pkg::KIND_SYMBOL;
      e1_sym  = '0;
      e1_err  = stk_pkg::ERR_NONE;
      e1_line = line_ff;
      e1_col  = col_ff;
      e1_len  = LEN_ONE;
      if (cmd == stk_pkg::CMD_BYTE) begin
         // extend or close the token in progress
         unique case (mode_ff)
            M_IDENT: begin
               if (stk_pkg::is_alpha(char_byte) || stk_pkg::is_digit(char_byte)) begin
                  cnt_in = cnt_inc;
               end else begin
                  e0_vld  = 1'b1;
                  restart = 1'b1;
               end
            end
            M_INT: begin
               if (stk_pkg::is_digit(char_byte)) begin
                  cnt_in = cnt_inc;
               end else if (char_byte == stk_pkg::CH_DOT) begin
                  cnt_in  = cnt_inc;
                  mode_in = M_DOT;
               end else begin
                  e0_vld  = 1'b1;
                  e0_kind = stk_pkg::KIND_INT;
                  restart = 1'b1;
               end
            end
            M_DOT: begin
               if (stk_pkg::is_digit(char_byte)) begin
                  cnt_in  = cnt_inc;
                  mode_in = M_FRAC;
               end else begin
                  e0_vld  = 1'b1;
                  e0_kind = stk_pkg::KIND_ERROR;
                  e0_err  = stk_pkg::ERR_NO_FRACTION;
                  e0_line = line_ff;
                  e0_col  = col_ff;
                  e0_len  = LEN_ZERO;
                  mode_in = M_ERROR;
               end
            end
            M_FRAC: begin
               if (stk_pkg::is_digit(char_byte)) begin
                  cnt_in = cnt_inc;
               end else begin
                  e0_vld  = 1'b1;
                  e0_kind = stk_pkg::KIND_FLOAT;
                  restart = 1'b1;
               end
            end
            M_OPER: begin
               e0_vld  = 1'b1;
               e0_kind = stk_pkg::KIND_SYMBOL;
               if (oi.n_ext != 2'd0 && char_byte == oi.ext1) begin
                  e0_sym  = oi.base + 6'd1;
                  e0_len  = LEN_TWO;
                  mode_in = M_IDLE;
                  pend_in = '0;
               end else if (oi.n_ext == 2'd2 && char_byte == oi.ext2) begin
                  e0_sym  = oi.base + 6'd2;
                  e0_len  = LEN_TWO;
                  mode_in = M_IDLE;
                  pend_in = '0;
               end else begin
                  e0_sym  = oi.base;
                  e0_len  = LEN_ONE;
                  restart = 1'b1;
               end
            end
            M_ERROR: begin
            end
            default: begin
               restart = 1'b1;
            end
         endcase

         // treat the byte as the start of what follows
         if (restart) begin
            mode_in = M_IDLE;
            pend_in = '0;
            priority if (stk_pkg::is_space(char_byte)) begin
            end else if (stk_pkg::is_alpha(char_byte)) begin
               mode_in = M_IDENT;
               tsl_in  = line_ff;
               tsc_in  = col_ff;
               cnt_in  = LEN_ONE;
            end else if (stk_pkg::is_digit(char_byte)) begin
               mode_in = M_INT;
               tsl_in  = line_ff;
               tsc_in  = col_ff;
               cnt_in  = LEN_ONE;
            end else if (sc.hit) begin
               e1_vld = 1'b1;
               e1_sym = sc.sym;
            end else if (oc != '0) begin
               mode_in = M_OPER;
               pend_in = oc;
               tsl_in  = line_ff;
               tsc_in  = col_ff;
               cnt_in  = LEN_ONE;
            end else begin
               e1_vld  = 1'b1;
               e1_kind = stk_pkg::KIND_ERROR;
               e1_err  = stk_pkg::ERR_UNEXPECTED;
               mode_in = M_ERROR;
            end
         end

         // advance the position, saturating
         if (char_byte == stk_pkg::CH_NL) begin
            line_in = (line_ff == '1) ? line_ff : line_ff + LINE_ONE;
            col_in  = COL_ONE;
         end else begin
            col_in  = (col_ff == '1) ? col_ff : col_ff + COL_ONE;
         end
      end else begin
         // end of data: flush the pending token, then report end of file
         unique case (mode_ff)
            M_IDENT: e0_vld = 1'b1;
            M_INT: begin
               e0_vld  = 1'b1;
               e0_kind = stk_pkg::KIND_INT;
            end
            M_FRAC: begin
               e0_vld  = 1'b1;
               e0_kind = stk_pkg::KIND_FLOAT;
            end
            M_DOT: begin
               e0_vld  = 1'b1;
               e0_kind = stk_pkg::KIND_ERROR;
               e0_err  = stk_pkg::ERR_NO_FRACTION;
               e0_line = line_ff;
               e0_col  = col_ff;
               e0_len  = LEN_ZERO;
            end
            M_OPER: begin
               e0_vld  = 1'b1;
               e0_kind = stk_pkg::KIND_SYMBOL;
               e0_sym  = oi.base;
               e0_len  = LEN_ONE;
            end
            default: begin
            end
         endcase
         e1_vld  = 1'b1;
         e1_kind = stk_pkg::KIND_EOF;
         e1_len  = LEN_ZERO;
         mode_in = M_IDLE;
         pend_in = '0;
         line_in = LINE_ONE;
         col_in  = COL_ONE;
         tsl_in  = LINE_ONE;
         tsc_in  = COL_ONE;
         cnt_in  = LEN_ZERO;
      end
   end

   // close up the two slots so the first valid token leads
   always_comb begin
      res_b = {e1_kind, e1_sym, e1_err, e1_line, e1_col, e1_len, 1'b1};
      if (e0_vld) begin
         res_a = {e0_kind, e0_sym, e0_err, e0_line, e0_col, e0_len, !e1_vld};
         res_n = e1_vld ? 2'd2 : 2'd1;
      end else begin
         res_a = res_b;
         res_n = {1'b0, e1_vld};
      end
   end

   // hold scan state between beats
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         pend_ff <= '0;
         line_ff <= LINE_ONE;
         col_ff  <= COL_ONE;
         tsl_ff  <= LINE_ONE;
         tsc_ff  <= COL_ONE;
         cnt_ff  <= LEN_ZERO;
      end else if (fire) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         tsl_ff  <= tsl_in;
         tsc_ff  <= tsc_in;
         cnt_ff  <= cnt_in;
      end
   end

   `STK_ASSERT_NEXT(a_end_clears_position, clock, reset,
      fire && cmd == stk_pkg::CMD_END, mode_ff == M_IDLE && line_ff == LINE_ONE && col_ff == COL_ONE)
   `STK_ASSERT_NOW(a_end_gives_token, clock, reset, cmd == stk_pkg::CMD_END, res_n != 2'd0)
   `STK_ASSERT_NOW(a_oper_has_pending, clock, reset,
      mode_ff == M_OPER, pend_ff != '0 && pend_ff <= 4'(stk_pkg::OP_COUNT))
   `STK_ASSERT_NOW(a_token_has_bytes, clock, reset,
      mode_ff == M_IDENT || mode_ff == M_INT || mode_ff == M_FRAC, cnt_ff != LEN_ZERO)

endmodule

// ===== rtl/core/stk_queue.sv =====
`include "source_char_tokenizer_core_defines.svh"

module stk_queue #(
   parameter int WIDTH = 61
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_n,
   input  logic [WIDTH-1:0] push_a,
   input  logic [WIDTH-1:0] push_b,
   input  logic             pop,
   output logic             room,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);

   localparam int DEPTH = stk_pkg::QUEUE_DEPTH;

   logic [WIDTH-1:0]            mem_ff [DEPTH];
   logic [stk_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [stk_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [stk_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic [stk_pkg::QPTR_W-1:0]  wr_next;

   assign wr_next   = wr_ptr_ff + stk_pkg::QPTR_W'(1);
   assign room      = count_ff <= stk_pkg::QCNT_W'(DEPTH - 2);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + stk_pkg::QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + stk_pkg::QPTR_W'(pop);
      count_in  = count_ff + stk_pkg::QCNT_W'(push_n) - stk_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store up to two beats per cycle
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_next] <= push_b;
      end
   end

   `STK_ASSERT_NOW(a_never_overfull, clock, reset, 1'b1, count_ff <= stk_pkg::QCNT_W'(DEPTH))
   `STK_ASSERT_NOW(a_push_has_room, clock, reset, push_n != 2'd0, room)
   `STK_ASSERT_NEXT(a_pop_drains, clock, reset,
      pop && push_n == 2'd0, count_ff == $past(count_ff) - stk_pkg::QCNT_W'(1))

endmodule

// ===== rtl/core/source_char_tokenizer_core.sv =====
// Streaming tokenizer for C-like source text.
// req_bus carries one beat per source byte (cmd low, char_byte) or an
// end-of-data beat (cmd high). rsp_bus carries one token per beat: kind,
// symbol code, error code, start line and column, length, and last_of_run
// marking the final token caused by one request beat.
// A request beat is taken into an input register; when the queue has room the scan
// logic works it against the lexer state and writes zero, one or two tokens
// into a four-entry response queue whose head drives rsp_bus. A token thus
// passes the input register and the queue before it is offered on rsp_bus.
// Throughput is one request beat per cycle while the response side keeps
// up; a beat is worked only when the queue has two free entries, so a burst
// of two-token beats runs at the rate the receiver drains tokens.
// When the receiver stalls, the queue fills, the input register holds and
// req_bus.ready drops; nothing is lost.
// Reset (synchronous, active high) empties the queue and input register and
// puts the lexer between tokens at line 1, column 1.
module source_char_tokenizer_core #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LENGTH_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   stk_req_if.sink   req_bus,
   stk_rsp_if.source rsp_bus
);

   localparam int RES_W   = 12 + LINE_BITS + COLUMN_BITS + LENGTH_BITS;
   localparam int LEN_LO  = 1;
   localparam int COL_LO  = LEN_LO + LENGTH_BITS;
   localparam int LINE_LO = COL_LO + COLUMN_BITS;
   localparam int ERR_LO  = LINE_LO + LINE_BITS;
   localparam int SYM_LO  = ERR_LO + 2;
   localparam int KIND_LO = SYM_LO + 6;

   logic             in_vld_ff;
   logic             in_cmd_ff;
   logic [7:0]       in_byte_ff;
   logic             fire;
   logic             room;
   logic             not_empty;
   logic [1:0]       res_n;
   logic [1:0]       push_n;
   logic [RES_W-1:0] res_a, res_b, head;

   assign fire          = in_vld_ff && room;
   assign req_bus.ready = !in_vld_ff || room;
   assign push_n        = fire ? res_n : 2'd0;

   // hold the accepted request beat until the queue can take its tokens
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_cmd_ff  <= req_bus.cmd;
         in_byte_ff <= req_bus.char_byte;
      end
   end

   stk_scan #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .RES_W       (RES_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .cmd       (in_cmd_ff),
      .char_byte (in_byte_ff),
      .res_n     (res_n),
      .res_a     (res_a),
      .res_b     (res_b)
   );

   stk_queue #(
      .WIDTH (RES_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_a    (res_a),
      .push_b    (res_b),
      .pop       (rsp_bus.valid && rsp_bus.ready),
      .room      (room),
      .not_empty (not_empty),
      .head      (head)
   );

   // drive the response beat from the queue head
   assign rsp_bus.valid        = not_empty;
   assign rsp_bus.token_kind   = head[KIND_LO +: 3];
   assign rsp_bus.symbol_code  = head[SYM_LO +: 6];
   assign rsp_bus.error_code   = head[ERR_LO +: 2];
   assign rsp_bus.token_line   = head[LINE_LO +: LINE_BITS];
   assign rsp_bus.start_column = head[COL_LO +: COLUMN_BITS];
   assign rsp_bus.token_length = head[LEN_LO +: LENGTH_BITS];
   assign rsp_bus.last_of_run  = head[0];

endmodule

// ===== bench/source_char_tokenizer_core_tb.sv =====
module source_char_tokenizer_core_tb;

   localparam int RANDOM_ITEMS = 1650;
   localparam int RUN_LIMIT    = 400000;
   localparam int N_SINGLE     = 10;
   localparam int N_LEAD       = 12;
   localparam int NO_LEAD      = -1;
   localparam stk_pkg::sym_type NO_SYMBOL = '0;
   localparam logic [15:0] FIELD_MAX = '1;

   // spellings: symbol codes follow from the position in these strings
   localparam logic [95:0] SINGLE_CHARS = "()[]{}.,:;";
   localparam logic [95:0] LEAD_CHARS   = "*/%+-<>=!&|^";
   localparam logic [95:0] SECOND_CHARS = "=/=+-<>==&|^";
   localparam logic [95:0] THIRD_CHARS  = " * ====     ";

   typedef enum logic [2:0] {
      LEX_IDLE, LEX_WORD, LEX_INT, LEX_DOT, LEX_FRAC, LEX_OP, LEX_ERROR
   } lex_mode_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_byte;
      logic       rush;
   } src_item_type;

   typedef struct packed {
      stk_pkg::kind_type kind;
      stk_pkg::sym_type  sym;
      stk_pkg::err_type  err;
      logic [15:0]       line;
      logic [15:0]       col;
      logic [15:0]       len;
      logic              last;
   } token_type;

   logic clock = 1'b0;
   logic reset;

   stk_req_if req_bus ();
   stk_rsp_if #(.LINE_BITS(16), .COLUMN_BITS(16), .LENGTH_BITS(16)) rsp_bus ();

   source_char_tokenizer_core #(
      .LINE_BITS   (16),
      .COLUMN_BITS (16),
      .LENGTH_BITS (16)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   src_item_type src_q[$];
   token_type    tok_q[$];
   src_item_type next_item;
   token_type    step_tok[2];
   int           step_n;

   // lexer state of the predictor
   lex_mode_type lex_mode;
   int           op_lead;
   logic [15:0]  pos_line, pos_col, tok_line, tok_col, tok_len;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;
   logic rsp_hold = 1'b0;
   int   req_gap = 0;
   int   rsp_wait = 0;
   int   queued = 0;
   int   beats_in = 0;
   int   tokens_checked = 0;
   int   eof_seen = 0;
   int   error_seen = 0;
   int   fail_count = 0;
   int   cycle_count = 0;

   function automatic logic [7:0] char_at(input logic [95:0] s, input int n, input int i);
      return s[8*(n-1-i) +: 8];
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return c == stk_pkg::CH_USCORE || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= stk_pkg::CH_ZERO && c <= stk_pkg::CH_NINE;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == stk_pkg::CH_SPACE || c == stk_pkg::CH_TAB || c == stk_pkg::CH_NL ||
             c == stk_pkg::CH_CR;
   endfunction

   function automatic int single_index(input logic [7:0] c);
      int i;
      for (i = 0; i < N_SINGLE; i++)
         if (char_at(SINGLE_CHARS, N_SINGLE, i) == c) return i;
      return NO_LEAD;
   endfunction

   function automatic int lead_index(input logic [7:0] c);
      int i;
      for (i = 0; i < N_LEAD; i++)
         if (char_at(LEAD_CHARS, N_LEAD, i) == c) return i;
      return NO_LEAD;
   endfunction

   // 0 when c does not extend the operator, else which second spelling
   function automatic int second_kind(input int i, input logic [7:0] c);
      logic [7:0] third;
      third = char_at(THIRD_CHARS, N_LEAD, i);
      if (c == char_at(SECOND_CHARS, N_LEAD, i)) return 1;
      if (third != stk_pkg::CH_SPACE && c == third) return 2;
      return 0;
   endfunction

   // one code for the lead alone, then one per second spelling
   function automatic stk_pkg::sym_type op_symbol(input int i, input int k);
      int code, j;
      code = N_SINGLE;
      for (j = 0; j < i; j++)
         code += (char_at(THIRD_CHARS, N_LEAD, j) == stk_pkg::CH_SPACE) ? 2 : 3;
      return stk_pkg::sym_type'(code + k);
   endfunction

   function automatic logic byte_known(input logic [7:0] c);
      return is_blank(c) || is_letter(c) || is_numeral(c) ||
             single_index(c) != NO_LEAD || lead_index(c) != NO_LEAD;
   endfunction

   function automatic int pick_wait();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
   endfunction

   task automatic lex_clear();
      lex_mode = LEX_IDLE;
      op_lead  = NO_LEAD;
      pos_line = 16'd1;
      pos_col  = 16'd1;
      tok_line = 16'd1;
      tok_col  = 16'd1;
      tok_len  = '0;
   endtask

   task automatic note_token(input stk_pkg::kind_type kind, input stk_pkg::sym_type sym,
                             input stk_pkg::err_type err,
                             input logic [15:0] line, input logic [15:0] col,
                             input logic [15:0] len);
      if (step_n < 2) begin
         step_tok[step_n] = '{kind, sym, err, line, col, len, 1'b0};
         step_n++;
      end
   endtask

   task automatic open_token(input lex_mode_type mode);
      lex_mode = mode;
      tok_line = pos_line;
      tok_col  = pos_col;
      tok_len  = 16'd1;
   endtask

   task automatic grow_token();
      if (tok_len != FIELD_MAX) tok_len++;
   endtask

   // work out the tokens that one accepted request beat causes
   task automatic lex_step(input logic cmd, input logic [7:0] c);
      logic restart;
      int   i, k;
      restart = 1'b0;
      step_n  = 0;
      if (cmd == stk_pkg::CMD_END) begin
         case (lex_mode)
            LEX_WORD: note_token(stk_pkg::KIND_IDENT, NO_SYMBOL, stk_pkg::ERR_NONE,
                                 tok_line, tok_col, tok_len);
            LEX_INT:  note_token(stk_pkg::KIND_INT, NO_SYMBOL, stk_pkg::ERR_NONE,
                                 tok_line, tok_col, tok_len);
            LEX_FRAC: note_token(stk_pkg::KIND_FLOAT, NO_SYMBOL, stk_pkg::ERR_NONE,
                                 tok_line, tok_col, tok_len);
            LEX_DOT:  note_token(stk_pkg::KIND_ERROR, NO_SYMBOL, stk_pkg::ERR_NO_FRACTION,
                                 pos_line, pos_col, '0);
            LEX_OP:   note_token(stk_pkg::KIND_SYMBOL, op_symbol(op_lead, 0),
                                 stk_pkg::ERR_NONE, tok_line, tok_col, 16'd1);
            default: ;
         endcase
         note_token(stk_pkg::KIND_EOF, NO_SYMBOL, stk_pkg::ERR_NONE, pos_line, pos_col, '0);
         lex_clear();
      end else begin
         case (lex_mode)
            LEX_WORD: begin
               if (is_letter(c) || is_numeral(c)) grow_token();
               else begin
                  note_token(stk_pkg::KIND_IDENT, NO_SYMBOL, stk_pkg::ERR_NONE,
                             tok_line, tok_col, tok_len);
                  restart = 1'b1;
               end
            end
            LEX_INT: begin
               if (is_numeral(c)) grow_token();
               else if (c == stk_pkg::CH_DOT) begin
                  grow_token();
                  lex_mode = LEX_DOT;
               end else begin
                  note_token(stk_pkg::KIND_INT, NO_SYMBOL, stk_pkg::ERR_NONE,
                             tok_line, tok_col, tok_len);
                  restart = 1'b1;
               end
            end
            LEX_DOT: begin
               if (is_numeral(c)) begin
                  grow_token();
                  lex_mode = LEX_FRAC;
               end else begin
                  note_token(stk_pkg::KIND_ERROR, NO_SYMBOL, stk_pkg::ERR_NO_FRACTION,
                             pos_line, pos_col, '0);
                  lex_mode = LEX_ERROR;
               end
            end
            LEX_FRAC: begin
               if (is_numeral(c)) grow_token();
               else begin
                  note_token(stk_pkg::KIND_FLOAT, NO_SYMBOL, stk_pkg::ERR_NONE,
                             tok_line, tok_col, tok_len);
                  restart = 1'b1;
               end
            end
            LEX_OP: begin
               k = second_kind(op_lead, c);
               if (k != 0) begin
                  note_token(stk_pkg::KIND_SYMBOL, op_symbol(op_lead, k), stk_pkg::ERR_NONE,
                             tok_line, tok_col, 16'd2);
                  lex_mode = LEX_IDLE;
                  op_lead  = NO_LEAD;
               end else begin
                  note_token(stk_pkg::KIND_SYMBOL, op_symbol(op_lead, 0), stk_pkg::ERR_NONE,
                             tok_line, tok_col, 16'd1);
                  restart = 1'b1;
               end
            end
            LEX_ERROR: ;
            default: restart = 1'b1;
         endcase
         // treat the byte as the start of whatever follows
         if (restart) begin
            lex_mode = LEX_IDLE;
            op_lead  = NO_LEAD;
            if (is_blank(c)) ;
            else if (is_letter(c)) open_token(LEX_WORD);
            else if (is_numeral(c)) open_token(LEX_INT);
            else if (single_index(c) != NO_LEAD)
               note_token(stk_pkg::KIND_SYMBOL, stk_pkg::sym_type'(single_index(c)),
                          stk_pkg::ERR_NONE, pos_line, pos_col, 16'd1);
            else if (lead_index(c) != NO_LEAD) begin
               open_token(LEX_OP);
               op_lead = lead_index(c);
            end else begin
               note_token(stk_pkg::KIND_ERROR, NO_SYMBOL, stk_pkg::ERR_UNEXPECTED,
                          pos_line, pos_col, 16'd1);
               lex_mode = LEX_ERROR;
            end
         end
         // advance the position, saturating
         if (c == stk_pkg::CH_NL) begin
            if (pos_line != FIELD_MAX) pos_line++;
            pos_col = 16'd1;
         end else if (pos_col != FIELD_MAX) begin
            pos_col++;
         end
      end
      for (i = 0; i < step_n; i++) begin
         step_tok[i].last = (i == step_n - 1);
         tok_q.push_back(step_tok[i]);
      end
   endtask

   // stimulus helpers
   task automatic push_byte(input logic [7:0] c, input logic rush);
      src_q.push_back('{stk_pkg::CMD_BYTE, c, rush});
      queued++;
   endtask

   task automatic push_end(input logic [7:0] c);
      src_q.push_back('{stk_pkg::CMD_END, c, 1'b0});
      queued++;
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_letter();
      int n;
      n = $urandom_range(0, 52);
      if (n == 52) return stk_pkg::CH_USCORE;
      return (n < 26) ? 8'h61 + 8'(n) : 8'h41 + 8'(n - 26);
   endfunction

   function automatic logic [7:0] pick_digit();
      return stk_pkg::CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0:       return stk_pkg::CH_SPACE;
         1:       return stk_pkg::CH_TAB;
         2:       return stk_pkg::CH_NL;
         default: return stk_pkg::CH_CR;
      endcase
   endfunction

   // bytes after an error are ignored until end of data, so close the run soon
   task automatic error_tail();
      int n;
      n = $urandom_range(0, 4);
      repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
      queued -= n;
      push_end(8'($urandom_range(0, 255)));
   endtask

   task automatic add_fragment();
      int         pick, i;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         push_byte(pick_letter(), 1'b0);
         repeat ($urandom_range(0, 7))
            push_byte(($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter(), 1'b0);
      end else if (pick < 45) begin
         repeat ($urandom_range(1, 5)) push_byte(pick_digit(), 1'b0);
      end else if (pick < 55) begin
         repeat ($urandom_range(1, 3)) push_byte(pick_digit(), 1'b0);
         push_byte(stk_pkg::CH_DOT, 1'b0);
         repeat ($urandom_range(1, 3)) push_byte(pick_digit(), 1'b0);
      end else if (pick < 75) begin
         i = $urandom_range(0, N_LEAD - 1);
         push_byte(char_at(LEAD_CHARS, N_LEAD, i), 1'b0);
         case ($urandom_range(0, 3))
            1: push_byte(char_at(SECOND_CHARS, N_LEAD, i), 1'b0);
            2: begin
               c = char_at(THIRD_CHARS, N_LEAD, i);
               push_byte((c == stk_pkg::CH_SPACE) ? stk_pkg::CH_EQUAL : c, 1'b0);
            end
            3: push_byte(char_at(LEAD_CHARS, N_LEAD, $urandom_range(0, N_LEAD - 1)), 1'b0);
            default: ;
         endcase
      end else if (pick < 80) begin
         push_byte(char_at(SINGLE_CHARS, N_SINGLE, $urandom_range(0, N_SINGLE - 1)), 1'b0);
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 3)) push_byte(pick_blank(), 1'b0);
      end else if (pick < 91) begin
         push_end(8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
         c = 8'($urandom_range(0, 255));
         push_byte(c, 1'b0);
         if (!byte_known(c)) error_tail();
      end else if (pick < 97) begin
         // number whose dot is followed by a non-digit
         push_byte(stk_pkg::CH_SPACE, 1'b0);
         repeat ($urandom_range(1, 3)) push_byte(pick_digit(), 1'b0);
         push_byte(stk_pkg::CH_DOT, 1'b0);
         do c = 8'($urandom_range(0, 255)); while (is_numeral(c));
         push_byte(c, 1'b0);
         error_tail();
      end else begin
         do c = 8'($urandom_range(0, 255)); while (byte_known(c));
         push_byte(c, 1'b0);
         error_tail();
      end
   endtask

   // request driver: present beats at the falling edge, hold until taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fire) begin
      end else if (req_gap > 0) begin
         req_bus.valid <= 1'b0;
         req_gap--;
      end else if (src_q.size() != 0) begin
         next_item = src_q.pop_front();
         req_bus.valid     <= 1'b1;
         req_bus.cmd       <= next_item.cmd;
         req_bus.char_byte <= next_item.char_byte;
         if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
         req_gap = (req_calm || (src_q.size() != 0 && src_q[0].rush)) ? 0 : pick_wait();
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // token receiver: stall after each beat, or for a long stretch on hold
   always @(negedge clock) begin
      if (rsp_fire) begin
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         rsp_wait = rsp_calm ? 0 : pick_wait();
      end
      if (reset || rsp_hold) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // hold the receiver off twice while requests keep coming
   initial begin
      while (beats_in < 300) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold = 1'b0;
      while (beats_in < 1100) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (250) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // monitor: predict on accepted requests, check accepted tokens
   always @(posedge clock) begin
      token_type got, want;
      cycle_count++;
      req_fire = !reset && req_bus.valid && req_bus.ready;
      rsp_fire = !reset && rsp_bus.valid && rsp_bus.ready;
      if (req_fire) begin
         beats_in++;
         lex_step(req_bus.cmd, req_bus.char_byte);
      end
      if (rsp_fire) begin
         got = '{stk_pkg::kind_type'(rsp_bus.token_kind), rsp_bus.symbol_code,
                 stk_pkg::err_type'(rsp_bus.error_code), rsp_bus.token_line,
                 rsp_bus.start_column, rsp_bus.token_length, rsp_bus.last_of_run};
         if (tok_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected token: kind %0d line %0d col %0d len %0d",
                        got.kind, got.line, got.col, got.len);
         end else begin
            want = tok_q.pop_front();
            tokens_checked++;
            if (want.kind == stk_pkg::KIND_EOF) eof_seen++;
            if (want.kind == stk_pkg::KIND_ERROR) error_seen++;
            if (got.kind !== want.kind || got.sym !== want.sym || got.err !== want.err ||
                got.line !== want.line || got.col !== want.col || got.len !== want.len ||
                got.last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"token %0d (expected/actual): kind %0d/%0d sym %0d/%0d ",
                            "err %0d/%0d line %0d/%0d col %0d/%0d len %0d/%0d last %0b/%0b"},
                           tokens_checked, want.kind, got.kind, want.sym, got.sym,
                           want.err, got.err, want.line, got.line, want.col, got.col,
                           want.len, got.len, want.last, got.last);
            end
         end
      end
      if (cycle_count >= RUN_LIMIT) begin
         $display("source_char_tokenizer_core: mismatch");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = stk_pkg::CMD_BYTE;
      req_bus.char_byte   = '0;
      rsp_bus.ready       = 1'b0;
      lex_clear();

      // directed: two tokens from one byte, a float and a number with no fraction, operators,
      // unknown bytes at both ends of the range, a dot before end of data
      push_text("_Z9(3.14\r\n");
      push_text("<<=//x");
      push_end(8'h00);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_end(8'hFF);
      push_text("7.");
      push_end(8'h5A);
      push_text("+");
      push_end(8'hA5);

      // random token streams with some noise and broken numbers
      queued = 0;
      while (queued < RANDOM_ITEMS) add_fragment();
      push_end(8'h00);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (src_q.size() != 0 || req_bus.valid) @(posedge clock);
      while (tok_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run covered %0d request beats and %0d tokens checked,", beats_in,
               tokens_checked);
      $display("including %0d error tokens and %0d end-of-file tokens", error_seen, eof_seen);
      if (fail_count == 0 && tok_q.size() == 0) begin
         $display("source_char_tokenizer_core: match");
      end else begin
         $display("source_char_tokenizer_core: mismatch");
      end
      $finish;
   end

endmodule
